// ----- hw/rtl/cma_pkg.sv -----
// Shared types and constants for the confusion matrix accumulator.
// Used by cma_acc_div and confusion_matrix_accumulator; depends on nothing.
`default_nettype none

package cma_pkg;

	localparam int CLASS_W         = 4;
	localparam int NUM_CLASSES_W   = 5;
	localparam logic [NUM_CLASSES_W-1:0] NUM_CLASSES_RST = 5'd16;
	localparam int OUT_W           = 32;
	localparam int ACC_FRAC_W      = 16;
	localparam int ACC_W           = ACC_FRAC_W + 1;
	localparam int ACC_STEP_W      = $clog2(ACC_FRAC_W + 1);

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	typedef enum logic [1:0] {
		OP_RECORD   = 2'd0,
		OP_CLEAR    = 2'd1,
		OP_READ     = 2'd2,
		OP_ACCURACY = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RMW   = 4'b0010,
		ST_DIV   = 4'b0100,
		ST_CLEAR = 4'b1000
	} state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cma_count_ram.sv -----
// Counter table memory: one write port, one read port, registered read data.
// Self-contained; no package needed.
`default_nettype none

module cma_count_ram #(
	parameter int DEPTH = 256,
	parameter int AW    = 8,
	parameter int DW    = 32
) (
	input  wire logic          clk,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [DW-1:0] rd_data,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/cma_acc_div.sv -----
// Serial restoring divider for the accuracy ratio, one quotient bit per cycle.
// Depends on cma_pkg for the fixed-point widths.
`default_nettype none

module cma_acc_div
	import cma_pkg::*;
#(
	parameter int CW = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             go,
	input  wire logic [CW-1:0]    dividend,
	input  wire logic [CW-1:0]    divisor,
	output logic                  done,
	output logic      [ACC_W-1:0] quot
);

	logic                  busy_q;
	logic                  done_q;
	logic [ACC_STEP_W-1:0] cnt_q;
	logic                  zero_q;
	logic [CW-1:0]         rem_q;
	logic [CW-1:0]         den_q;
	logic [ACC_W-1:0]      q_q;
	logic [ACC_W-1:0]      quot_q;

	logic [CW:0] rem2;
	logic [CW:0] diff;
	logic        ge;

	// The dividend never exceeds the divisor, so the remainder stays below the
	// divisor and doubling it fits in one extra bit. In the last cycle the same
	// compare decides the round-half-up.
	assign rem2 = {rem_q, 1'b0};
	assign diff = rem2 - {1'b0, den_q};
	assign ge   = (rem2 >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= ACC_STEP_W'(ACC_FRAC_W);
			end else if (busy_q) begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			zero_q <= (divisor == '0);
			den_q  <= divisor;
			if (dividend >= divisor) begin
				rem_q <= dividend - divisor;
				q_q   <= ACC_W'(1);
			end else begin
				rem_q <= dividend;
				q_q   <= '0;
			end
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				rem_q <= ge ? diff[CW-1:0] : rem2[CW-1:0];
				q_q   <= {q_q[ACC_W-2:0], ge};
			end else begin
				quot_q <= zero_q ? '0 : (q_q + ACC_W'(ge));
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

`default_nettype wire

// ----- hw/rtl/confusion_matrix_accumulator.sv -----
// Top level of the confusion matrix accumulator: sequencer, totals, outputs.
// Depends on cma_pkg, cma_count_ram and cma_acc_div.
`default_nettype none

// A transaction is taken at a rising edge where start is high and busy is low,
// and every transaction yields exactly one result, shown for one cycle with
// done high, except an accuracy query cut off by a write of num_classes. The
// receiver cannot stall, so results must be captured on that cycle. Record
// and read of an in-range cell go through the table read and then the RMW
// state, where a record updates the cell and writes it back through the
// registered-read memory. An accuracy query runs the serial divider: a setup
// step, 16 quotient steps, a rounding step into the divider's result register,
// then the result register here. After either, the next transaction can be
// taken while done is high. Out-of-range record or read and clear return
// their result in the cycle after they are taken; the former leave busy low,
// while clear keeps busy high as the table is swept to zero. The same sweep
// runs after reset and after every write of num_classes, which also zeroes
// both totals. Busy is also high in a cycle where num_classes is written, so
// no transaction is taken at that edge. Counts saturate at the counter
// maximum and are reported clipped to 32 bits.

module confusion_matrix_accumulator
	import cma_pkg::*;
#(
	parameter int MAX_CLASSES = 16,
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [1:0]               opcode,
	input  wire logic [CLASS_W-1:0]       actual_class,
	input  wire logic [CLASS_W-1:0]       predicted_class,
	input  wire logic                     cfg_we,
	input  wire logic [NUM_CLASSES_W-1:0] cfg_wdata,
	output logic                          done,
	output logic                          status,
	output logic      [OUT_W-1:0]         cell_count,
	output logic      [OUT_W-1:0]         correct_count,
	output logic      [OUT_W-1:0]         total_count,
	output logic      [ACC_W-1:0]         accuracy_q16
);

	localparam int DEPTH = MAX_CLASSES * MAX_CLASSES;
	localparam int AW    = $clog2(DEPTH);
	localparam int NW    = ($clog2(MAX_CLASSES + 1) > NUM_CLASSES_W) ?
	                       $clog2(MAX_CLASSES + 1) : NUM_CLASSES_W;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	// Clip a counter to the 32-bit result fields.
	function automatic logic [OUT_W-1:0] clip_out(input logic [COUNT_WIDTH-1:0] v);
		logic [COUNT_WIDTH+OUT_W-1:0] w;
		w = {{OUT_W{1'b0}}, v};
		if (w > {{COUNT_WIDTH{1'b0}}, {OUT_W{1'b1}}}) begin
			return '1;
		end
		return w[OUT_W-1:0];
	endfunction

	state_t                   state_q;
	logic [AW-1:0]            clr_addr_q;
	logic [NUM_CLASSES_W-1:0] num_classes_q;
	logic [COUNT_WIDTH-1:0]   diag_q;
	logic [COUNT_WIDTH-1:0]   grand_q;
	logic                     done_q;

	// Transaction held while the table entry is read and updated.
	op_t                      op_q;
	logic [AW-1:0]            addr_q;
	logic                     hit_q;

	logic                     status_q;
	logic [OUT_W-1:0]         cell_q;
	logic [OUT_W-1:0]         correct_q;
	logic [OUT_W-1:0]         total_q;
	logic [ACC_W-1:0]         acc_q;

	op_t                      op_in;
	logic                     accept;
	logic [NW-1:0]            n_eff;
	logic                     idx_ok;
	logic [AW-1:0]            item_addr;

	logic [COUNT_WIDTH-1:0]   rd_data;
	logic                     wr_en;
	logic [AW-1:0]            wr_addr;
	logic [COUNT_WIDTH-1:0]   wr_data;

	logic                     do_inc;
	logic [COUNT_WIDTH-1:0]   cell_new;
	logic [COUNT_WIDTH-1:0]   diag_nxt;
	logic [COUNT_WIDTH-1:0]   grand_nxt;

	logic                     div_go;
	logic                     div_done;
	logic [ACC_W-1:0]         div_quot;

	logic                     res_load;
	logic                     res_status;
	logic [OUT_W-1:0]         res_cell;
	logic [OUT_W-1:0]         res_correct;
	logic [OUT_W-1:0]         res_total;
	logic [ACC_W-1:0]         res_acc;

	assign op_in  = op_t'(opcode);
	assign busy   = (state_q != ST_IDLE) || cfg_we;
	assign accept = start && !busy;

	// A class count above the table size behaves as the table size.
	assign n_eff = (NW'(num_classes_q) > NW'(MAX_CLASSES)) ?
	               NW'(MAX_CLASSES) : NW'(num_classes_q);
	assign idx_ok = (NW'(actual_class) < n_eff) && (NW'(predicted_class) < n_eff);
	assign item_addr = AW'(int'(actual_class) * MAX_CLASSES + int'(predicted_class));

	// Read-modify-write of one cell. The sequencer never overlaps two
	// transactions, so the write-back lands before the next read is issued.
	assign do_inc    = (state_q == ST_RMW) && (op_q == OP_RECORD) &&
	                   (rd_data != COUNT_MAX) && (grand_q != COUNT_MAX);
	assign cell_new  = do_inc ? (rd_data + 1'b1) : rd_data;
	assign grand_nxt = do_inc ? (grand_q + 1'b1) : grand_q;
	assign diag_nxt  = (do_inc && hit_q) ? (diag_q + 1'b1) : diag_q;

	assign wr_en   = (state_q == ST_CLEAR) || do_inc;
	assign wr_addr = (state_q == ST_CLEAR) ? clr_addr_q : addr_q;
	assign wr_data = (state_q == ST_CLEAR) ? '0 : cell_new;

	cma_count_ram #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (COUNT_WIDTH)
	) u_ram (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (item_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	assign div_go = accept && (op_in == OP_ACCURACY);

	cma_acc_div #(
		.CW (COUNT_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (diag_q),
		.divisor  (grand_q),
		.done     (div_done),
		.quot     (div_quot)
	);

	// Result selection. Every path that finishes a transaction raises res_load
	// for exactly one cycle.
	always_comb begin
		res_load    = 1'b0;
		res_status  = STATUS_OK;
		res_cell    = '0;
		res_correct = clip_out(diag_q);
		res_total   = clip_out(grand_q);
		res_acc     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (op_in == OP_CLEAR) begin
						res_load    = 1'b1;
						res_correct = '0;
						res_total   = '0;
					end else if (op_in != OP_ACCURACY && !idx_ok) begin
						res_load   = 1'b1;
						res_status = STATUS_RANGE;
					end
				end
			end
			ST_RMW: begin
				res_load    = 1'b1;
				res_cell    = clip_out(cell_new);
				res_correct = clip_out(diag_nxt);
				res_total   = clip_out(grand_nxt);
			end
			ST_DIV: begin
				if (div_done) begin
					res_load = 1'b1;
					res_acc  = div_quot;
				end
			end
			ST_CLEAR: begin
				res_load = 1'b0;
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_addr_q    <= '0;
			num_classes_q <= NUM_CLASSES_RST;
			diag_q        <= '0;
			grand_q       <= '0;
			done_q        <= 1'b0;
		end else begin
			done_q <= res_load;
			if (cfg_we) begin
				// A new class count re-initializes the table.
				num_classes_q <= cfg_wdata;
				diag_q        <= '0;
				grand_q       <= '0;
				clr_addr_q    <= '0;
				state_q       <= ST_CLEAR;
			end else begin
				unique case (state_q)
					ST_IDLE: begin
						if (accept) begin
							if (op_in == OP_CLEAR) begin
								diag_q     <= '0;
								grand_q    <= '0;
								clr_addr_q <= '0;
								state_q    <= ST_CLEAR;
							end else if (op_in == OP_ACCURACY) begin
								state_q <= ST_DIV;
							end else if (idx_ok) begin
								state_q <= ST_RMW;
							end
						end
					end
					ST_RMW: begin
						diag_q  <= diag_nxt;
						grand_q <= grand_nxt;
						state_q <= ST_IDLE;
					end
					ST_DIV: begin
						if (div_done) begin
							state_q <= ST_IDLE;
						end
					end
					ST_CLEAR: begin
						clr_addr_q <= clr_addr_q + 1'b1;
						if (clr_addr_q == AW'(DEPTH - 1)) begin
							state_q <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_in;
			addr_q <= item_addr;
			hit_q  <= (actual_class == predicted_class);
		end
		if (res_load) begin
			status_q  <= res_status;
			cell_q    <= res_cell;
			correct_q <= res_correct;
			total_q   <= res_total;
			acc_q     <= res_acc;
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign cell_count    = cell_q;
	assign correct_count = correct_q;
	assign total_count   = total_q;
	assign accuracy_q16  = acc_q;

endmodule

`default_nettype wire
